// ===== hw/rtl/msis_pkg.sv =====
// ----------------------------------------------------------------------------
// msis_pkg
// Shared types and constants for the max-sum increasing subsequence core:
// sum width, parameter defaults, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package msis_pkg;

   // fixed field widths
   localparam int unsigned SUM_BITS    = 26;
   localparam int unsigned IN_BITS     = 16;

   // parameter defaults
   localparam int unsigned DEPTH_DEF      = 1024;
   localparam int unsigned VALUE_BITS_DEF = 16;

   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // latch incoming item, restart scan
      logic scan_rd;  // read entry at scan index, advance index
      logic write;    // store value and best-sum at fill position
      logic emit;     // load result register, clear sequence state
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;        // store holds DEPTH entries
      logic count_zero;  // no entries stored yet
      logic scan_end;    // current scan read is the last stored entry
      logic last;        // latched item closes the sequence
      logic out_free;    // result register can take a new item
   } status_type;

endpackage

// ===== hw/rtl/msis_ctrl.sv =====
// ----------------------------------------------------------------------------
// msis_ctrl
// Sequencer for one item: accept, walk the stored entries, write the new
// entry (both skipped when the store is full), then hand off the result when the item closes a sequence.
// ----------------------------------------------------------------------------
module msis_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  msis_pkg::status_type  sts,
   output msis_pkg::cmd_type     cmd
);
   import msis_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               priority if (sts.full) begin
                  state_in = ST_FINISH;
               end else if (sts.count_zero) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         // last read data is compared here
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            priority if (!sts.last) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end else begin
               // result register still busy: hold
               state_in = ST_FINISH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/msis_dp.sv =====
// ----------------------------------------------------------------------------
// msis_dp
// Datapath: entry store (value and best-sum per entry), scan compare,
// saturating sum, running maximum, overflow flag and the result register.
// ----------------------------------------------------------------------------
module msis_dp #(
   parameter int unsigned DEPTH      = msis_pkg::DEPTH_DEF,
   parameter int unsigned VALUE_BITS = msis_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [msis_pkg::IN_BITS-1:0]  req_value,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [msis_pkg::SUM_BITS-1:0] rsp_best_sum,
   output logic                          rsp_overflow,
   input  msis_pkg::cmd_type             cmd,
   output msis_pkg::status_type          sts
);
   import msis_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned EW = VALUE_BITS + SUM_BITS;
   localparam int unsigned SW = ((SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS) + 1;

   // entry store: {value, best-sum}
   logic [EW-1:0]         mem [DEPTH];
   logic [EW-1:0]         rd_data_ff;
   logic                  rd_vld_ff;

   logic [VALUE_BITS-1:0] val_ff;
   logic                  last_ff;
   logic [AW-1:0]         idx_ff;
   logic [CW-1:0]         count_ff;
   logic [SUM_BITS-1:0]   best_prev_ff;
   logic [SUM_BITS-1:0]   best_prev_in;
   logic [SUM_BITS-1:0]   overall_ff;
   logic                  ovf_ff;

   logic                  rsp_valid_ff;
   logic [SUM_BITS-1:0]   rsp_sum_ff;
   logic                  rsp_ovf_ff;

   logic [VALUE_BITS-1:0] rd_val;
   logic [SUM_BITS-1:0]   rd_sum;
   logic [SW-1:0]         mine_wide;
   logic [SUM_BITS-1:0]   mine;

   assign rd_val = rd_data_ff[EW-1:SUM_BITS];
   assign rd_sum = rd_data_ff[SUM_BITS-1:0];

   // store write and registered scan read
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[count_ff[AW-1:0]] <= {val_ff, mine};
      end
      if (cmd.scan_rd) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   // keep the largest sum among smaller earlier values
   always_comb begin
      best_prev_in = best_prev_ff;
      if (rd_vld_ff && (rd_val < val_ff) && (rd_sum > best_prev_ff)) begin
         best_prev_in = rd_sum;
      end
   end

   // new best-sum, saturated to the sum width
   assign mine_wide = SW'(best_prev_ff) + SW'(val_ff);
   assign mine      = (mine_wide > SW'(SUM_MAX)) ? SUM_MAX : mine_wide[SUM_BITS-1:0];

   // item payload and scan registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         val_ff       <= VALUE_BITS'(req_value);
         last_ff      <= req_last;
         idx_ff       <= '0;
         best_prev_ff <= '0;
      end else begin
         best_prev_ff <= best_prev_in;
         if (cmd.scan_rd) begin
            idx_ff <= idx_ff + AW'(1);
         end
      end
   end

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         overall_ff <= '0;
         ovf_ff     <= 1'b0;
         rd_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_rd;
         if (cmd.emit) begin
            count_ff   <= '0;
            overall_ff <= '0;
            ovf_ff     <= 1'b0;
         end else begin
            if (cmd.accept && sts.full) begin
               ovf_ff <= 1'b1;
            end
            if (cmd.write) begin
               count_ff <= count_ff + CW'(1);
               if (mine > overall_ff) begin
                  overall_ff <= mine;
               end
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_sum_ff <= overall_ff;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_best_sum = rsp_sum_ff;
   assign rsp_overflow = rsp_ovf_ff;

   // status to controller
   assign sts.full       = (count_ff == CW'(DEPTH));
   assign sts.count_zero = (count_ff == '0);
   assign sts.scan_end   = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign sts.last       = last_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

// ===== hw/rtl/max_sum_increasing_subsequence_core.sv =====
// ----------------------------------------------------------------------------
// max_sum_increasing_subsequence_core
// Streams a sequence of unsigned values (req_value, req_last on the final
// one) and returns the largest sum of a strictly increasing subsequence.
//
// Input channel req_*: one value per item, valid/ready. Only the low
// VALUE_BITS bits of req_value are used.
// Result channel rsp_*: one item per sequence, on the item with req_last:
// rsp_best_sum and rsp_overflow (more than DEPTH values, extras ignored).
// One item is processed at a time: the core reads and compares the stored
// entries (ST_SCAN, ST_DRAIN), writes the new entry (ST_WRITE), and returns
// req_ready after ST_FINISH; no scan with no values stored, no scan or write
// with the store full. The scan reads one stored entry per cycle from a
// single-port entry memory; rsp_valid rises in the cycle after the emit.
// Reset clears the sequence state and the result valid flag; the entry memory
// needs no clearing. If the receiver stalls, the result waits in its output
// register and the core keeps accepting items; only a second result that
// finds the register still full holds the core until rsp_ready.
// ----------------------------------------------------------------------------
module max_sum_increasing_subsequence_core #(
   parameter int unsigned DEPTH      = msis_pkg::DEPTH_DEF,
   parameter int unsigned VALUE_BITS = msis_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [msis_pkg::IN_BITS-1:0]  req_value,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [msis_pkg::SUM_BITS-1:0] rsp_best_sum,
   output logic                          rsp_overflow
);
   import msis_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // sequencer
   msis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // store, compare and result path
   msis_dp #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_value    (req_value),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_best_sum (rsp_best_sum),
      .rsp_overflow (rsp_overflow),
      .cmd          (cmd),
      .sts          (sts)
   );

   // one item in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous item still in work");

   // never write past capacity
   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> !sts.full)
      else $error("store write with store full");

   // a result never overwrites a pending one
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result emitted into busy output register");

   // emitted result shows up on the port and the sequence state is cleared
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_valid && sts.count_zero))
      else $error("emit did not present result or clear sequence");

endmodule
